// ===== sv/pkpt_pkg.sv =====
// ----------------------------------------------------------------------------
// pkpt_pkg
// Types and constants of the pointer keyed probe table.
// ----------------------------------------------------------------------------
package pkpt_pkg;

  localparam int unsigned SLOT_COUNT = 4096;
  localparam int unsigned SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int unsigned MIX_SHIFT  = 13;
  localparam int unsigned MIX_BITS   = SLOT_BITS + MIX_SHIFT;

  localparam logic [63:0] MIX_FACTOR  = 64'h0000_0000_9E37_79B1;
  localparam logic [63:0] KEY_EMPTY   = 64'd0;
  localparam logic [63:0] KEY_DELETED = 64'd1;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_LOOKUP   = 2'd1,
    CMD_FORGET   = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RESERVED  = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_MIX    = 7'b0000100,
    S_HASH   = 7'b0001000,
    S_READ   = 7'b0010000,
    S_CHECK  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

endpackage

// ===== sv/pointer_keyed_probe_table_top.sv =====
// ----------------------------------------------------------------------------
// pointer_keyed_probe_table_top
// Open-addressing hash table with linear probing and deleted-slot markers.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset, and after every clear command, the
// key store is swept empty one slot per cycle, all SLOT_COUNT (4096) slots,
// with req_stall high. Register, lookup and forget accept the key in idle,
// register the mix product in S_MIX and the home slot in S_HASH, then take
// each probed slot through S_READ (one synchronous read of the key and value
// stores) and S_CHECK (the compare), and load the response register in
// S_FINISH. A reserved key goes from idle straight to S_FINISH. A new request
// is taken while the previous response still waits on rsp_stall.
module pointer_keyed_probe_table_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  pkpt_pkg::cmd_t     command,
  input  logic [63:0]        key,
  input  logic [15:0]        resource_number,
  input  logic [15:0]        frame_number,
  input  logic [31:0]        fingerprint,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pkpt_pkg::status_t  status,
  output logic [15:0]        found_resource,
  output logic [15:0]        found_frame,
  output logic [31:0]        found_fingerprint
);
  import pkpt_pkg::*;

  state_t               state;
  cmd_t                 cmd_q;
  logic [63:0]          key_q;
  logic [63:0]          val_q;
  logic [MIX_BITS-1:0]  prod;
  logic [SLOT_BITS-1:0] slot;
  logic [SLOT_BITS-1:0] probe;
  logic [SLOT_BITS-1:0] ins;
  logic                 ins_valid;
  logic [SLOT_BITS-1:0] clr_cnt;
  logic                 clr_reply;
  status_t              res_status;
  logic [63:0]          res_val;

  logic [63:0]          key_mem [SLOT_COUNT];
  logic [63:0]          val_mem [SLOT_COUNT];
  logic [63:0]          rd_key;
  logic [63:0]          rd_val;

  logic                 kw_en;
  logic [SLOT_BITS-1:0] kw_addr;
  logic [63:0]          kw_data;
  logic                 vw_en;

  logic                 chk_done;
  logic                 chk_hit;
  status_t              chk_status;

  logic                 accept;
  logic [MIX_BITS-1:0]  mix_lo;
  logic [SLOT_BITS-1:0] start;
  logic                 match;
  logic                 is_empty;
  logic                 is_deleted;
  logic                 last;
  logic [SLOT_BITS-1:0] free_slot;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // only the low bits of the mix reach the slot index
  assign mix_lo = key_q[MIX_BITS-1:0] ^ key_q[MIX_BITS+15:16];
  assign start  = prod[SLOT_BITS-1:0] ^ prod[MIX_BITS-1:MIX_SHIFT];

  assign match      = (rd_key == key_q);
  assign is_empty   = (rd_key == KEY_EMPTY);
  assign is_deleted = (rd_key == KEY_DELETED);
  assign last       = (probe == SLOT_BITS'(SLOT_COUNT - 1));
  assign free_slot  = ins_valid ? ins : slot;

  always_comb begin
    kw_en      = 1'b0;
    kw_addr    = slot;
    kw_data    = key_q;
    vw_en      = 1'b0;
    chk_done   = 1'b0;
    chk_hit    = 1'b0;
    chk_status = ST_DONE;
    if (state == S_CLEAR) begin
      kw_en   = 1'b1;
      kw_addr = clr_cnt;
      kw_data = KEY_EMPTY;
    end else if (state == S_CHECK) begin
      case (cmd_q)
        CMD_REGISTER: begin
          if (match) begin
            kw_en    = 1'b1;
            vw_en    = 1'b1;
            chk_done = 1'b1;
          end else if (is_empty || (last && (ins_valid || is_deleted))) begin
            kw_en    = 1'b1;
            vw_en    = 1'b1;
            kw_addr  = free_slot;
            chk_done = 1'b1;
          end else if (last) begin
            chk_done   = 1'b1;
            chk_status = ST_FULL;
          end
        end
        CMD_LOOKUP: begin
          if (match) begin
            chk_done = 1'b1;
            chk_hit  = 1'b1;
          end else if (is_empty || last) begin
            chk_done   = 1'b1;
            chk_status = ST_NOT_FOUND;
          end
        end
        CMD_FORGET: begin
          if (match) begin
            kw_en    = 1'b1;
            kw_data  = KEY_DELETED;
            chk_done = 1'b1;
          end else if (is_empty || last) begin
            chk_done   = 1'b1;
            chk_status = ST_NOT_FOUND;
          end
        end
        default: begin
          chk_done = 1'b1;
        end
      endcase
    end
  end

  // key and value stores
  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[kw_addr] <= kw_data;
    end
    rd_key <= key_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (vw_en) begin
      val_mem[kw_addr] <= val_q;
    end
    rd_val <= val_mem[slot];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      key_q <= key;
      val_q <= {fingerprint, frame_number, resource_number};
    end
    if (state == S_MIX) begin
      prod <= MIX_BITS'(mix_lo * MIX_FACTOR[MIX_BITS-1:0]);
    end
    if (state == S_CHECK && cmd_q == CMD_REGISTER && is_deleted && !ins_valid) begin
      ins <= slot;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      clr_reply  <= 1'b0;
      slot       <= '0;
      probe      <= '0;
      ins_valid  <= 1'b0;
      res_status <= ST_DONE;
      res_val    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SLOT_BITS'(SLOT_COUNT - 1)) begin
            state <= clr_reply ? S_FINISH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_val <= '0;
            if (command == CMD_CLEAR) begin
              res_status <= ST_DONE;
              clr_cnt    <= '0;
              clr_reply  <= 1'b1;
              state      <= S_CLEAR;
            end else if (key == KEY_EMPTY || key == KEY_DELETED) begin
              res_status <= ST_RESERVED;
              state      <= S_FINISH;
            end else begin
              res_status <= ST_DONE;
              state      <= S_MIX;
            end
          end
        end
        S_MIX: begin
          state <= S_HASH;
        end
        S_HASH: begin
          slot      <= start;
          probe     <= '0;
          ins_valid <= 1'b0;
          state     <= S_READ;
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (cmd_q == CMD_REGISTER && is_deleted) begin
            ins_valid <= 1'b1;
          end
          if (chk_done) begin
            res_status <= chk_status;
            res_val    <= chk_hit ? rd_val : '0;
            state      <= S_FINISH;
          end else begin
            slot  <= slot + 1'b1;
            probe <= probe + 1'b1;
            state <= S_READ;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            status            <= res_status;
            found_resource    <= res_val[15:0];
            found_frame       <= res_val[31:16];
            found_fingerprint <= res_val[63:32];
            rsp_valid         <= 1'b1;
            clr_reply         <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/probe_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probe_table_checker
// Watches both channels of the probe table, keeps its own copy of the slot
// store, predicts the reply of every accepted request and compares each
// accepted reply against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module probe_table_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  pkpt_pkg::cmd_t    command,
  input  logic [63:0]       key,
  input  logic [15:0]       resource_number,
  input  logic [15:0]       frame_number,
  input  logic [31:0]       fingerprint,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  pkpt_pkg::status_t status,
  input  logic [15:0]       found_resource,
  input  logic [15:0]       found_frame,
  input  logic [31:0]       found_fingerprint,
  output int                fail_count,
  output int                pending
);
  import pkpt_pkg::*;

  typedef struct packed {
    status_t     st;
    logic [15:0] res;
    logic [15:0] frm;
    logic [31:0] fp;
  } reply_t;

  logic [63:0] slot_key [SLOT_COUNT];
  logic [63:0] slot_val [SLOT_COUNT];
  reply_t      expected_replies [$];

  function automatic int unsigned home_slot(input logic [63:0] k);
    logic [63:0] x;
    x = k ^ (k >> 16);
    x = x * MIX_FACTOR;
    x = x ^ (x >> 13);
    return int'(x % SLOT_COUNT);
  endfunction

  function automatic int unsigned step_slot(input int unsigned s);
    return (s + 1 >= SLOT_COUNT) ? 0 : s + 1;
  endfunction

  function automatic void empty_table();
    for (int i = 0; i < SLOT_COUNT; i++) slot_key[i] = KEY_EMPTY;
  endfunction

  // walks the chain, skipping deleted slots, stopping at an empty one
  function automatic int locate_key(input logic [63:0] k);
    int unsigned s;
    s = home_slot(k);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_key[s] == k) return int'(s);
      if (slot_key[s] == KEY_EMPTY) return -1;
      s = step_slot(s);
    end
    return -1;
  endfunction

  function automatic reply_t table_apply(input cmd_t c, input logic [63:0] k,
                                         input logic [15:0] r, input logic [15:0] f,
                                         input logic [31:0] p);
    reply_t      rep;
    int          slot;
    int unsigned s;
    rep = '0;
    rep.st = ST_DONE;
    if (c == CMD_CLEAR) begin
      empty_table();
    end else if (k == KEY_EMPTY || k == KEY_DELETED) begin
      rep.st = ST_RESERVED;
    end else if (c == CMD_REGISTER) begin
      // same key wins, else first deleted or empty slot on the chain
      slot = -1;
      s = home_slot(k);
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_key[s] == k) begin
          slot = int'(s);
          break;
        end
        if (slot_key[s] == KEY_EMPTY || slot_key[s] == KEY_DELETED) begin
          if (slot < 0) slot = int'(s);
          if (slot_key[s] == KEY_EMPTY) break;
        end
        s = step_slot(s);
      end
      if (slot < 0) begin
        rep.st = ST_FULL;
      end else begin
        slot_key[slot] = k;
        slot_val[slot] = {p, f, r};
      end
    end else begin
      slot = locate_key(k);
      if (slot < 0) rep.st = ST_NOT_FOUND;
      else if (c == CMD_LOOKUP) {rep.fp, rep.frm, rep.res} = slot_val[slot];
      else slot_key[slot] = KEY_DELETED;
    end
    return rep;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    fail_count++;
    $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      empty_table();
      expected_replies.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_replies.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction, expected none actual status %0d",
                   $time, status);
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.st) note_mismatch("status", want.st, status);
          if (found_resource !== want.res)
            note_mismatch("found_resource", want.res, found_resource);
          if (found_frame !== want.frm) note_mismatch("found_frame", want.frm, found_frame);
          if (found_fingerprint !== want.fp)
            note_mismatch("found_fingerprint", want.fp, found_fingerprint);
        end
      end
      if (req_valid && !req_stall)
        expected_replies.push_back(table_apply(command, key, resource_number,
                                               frame_number, fingerprint));
    end
    pending = expected_replies.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the pointer keyed probe table: directed corner cases
// (reserved keys, overwrite, tombstone reuse and skipping, wrap of the
// probe chain, clear), then random traffic over a small key pool under
// three idling profiles.
// ----------------------------------------------------------------------------
module tb;
  import pkpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int POOL_SIZE      = 24;

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        req_valid       = 1'b0;
  logic        rsp_stall       = 1'b0;
  cmd_t        command         = CMD_REGISTER;
  logic [63:0] key             = 64'd0;
  logic [15:0] resource_number = 16'd0;
  logic [15:0] frame_number    = 16'd0;
  logic [31:0] fingerprint     = 32'd0;

  logic        req_stall;
  logic        rsp_valid;
  status_t     status;
  logic [15:0] found_resource;
  logic [15:0] found_frame;
  logic [31:0] found_fingerprint;

  int fail_count;
  int pending;
  int send_idle_pct = 31;
  int recv_idle_pct = 82;
  int quiet_cycles  = 0;

  logic [63:0] key_pool [POOL_SIZE];
  logic [63:0] slot_cover [SLOT_COUNT];
  logic [63:0] col_a, col_b, wrap_a, wrap_b;

  always #5 clk = ~clk;

  pointer_keyed_probe_table_top DUT (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .command           (command),
    .key               (key),
    .resource_number   (resource_number),
    .frame_number      (frame_number),
    .fingerprint       (fingerprint),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .status            (status),
    .found_resource    (found_resource),
    .found_frame       (found_frame),
    .found_fingerprint (found_fingerprint)
  );

  probe_table_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .command           (command),
    .key               (key),
    .resource_number   (resource_number),
    .frame_number      (frame_number),
    .fingerprint       (fingerprint),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .status            (status),
    .found_resource    (found_resource),
    .found_frame       (found_frame),
    .found_fingerprint (found_fingerprint),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always @(negedge clk) rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("pointer_keyed_probe_table_top regression: fail");
        $finish;
      end
    end
  end

  function automatic int unsigned home_slot(input logic [63:0] k);
    logic [63:0] x;
    x = k ^ (k >> 16);
    x = x * MIX_FACTOR;
    x = x ^ (x >> 13);
    return int'(x % SLOT_COUNT);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input cmd_t c, input logic [63:0] k,
                              input logic [15:0] r, input logic [15:0] f,
                              input logic [31:0] p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid       = 1'b1;
    command         = c;
    key             = k;
    resource_number = r;
    frame_number    = f;
    fingerprint     = p;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_burst(input int count);
    int          done_n;
    int          pick;
    logic [63:0] k;
    cmd_t        c;
    done_n = 0;
    while (done_n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 1) c = CMD_CLEAR;
      else if (pick < 41) c = CMD_REGISTER;
      else if (pick < 71) c = CMD_LOOKUP;
      else c = CMD_FORGET;
      pick = $urandom_range(0, 99);
      if (pick < 4) k = 64'($urandom_range(0, 1));
      else if (pick < 12) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(c, k, 16'($urandom), 16'($urandom), $urandom);
      if (c == CMD_CLEAR || k > KEY_DELETED) done_n++;
    end
  endtask

  initial begin
    int unsigned hits;
    logic [63:0] k;

    // two keys sharing a home slot
    for (int i = 0; i < SLOT_COUNT; i++) slot_cover[i] = 64'd0;
    k = 64'd2;
    while (slot_cover[home_slot(k)] == 64'd0) begin
      slot_cover[home_slot(k)] = k;
      k++;
    end
    col_a = slot_cover[home_slot(k)];
    col_b = k;

    // two keys homed on the last slot, the second wraps to slot zero
    hits = 0;
    k = 64'd2;
    while (hits < 2) begin
      if (home_slot(k) == SLOT_COUNT - 1) begin
        if (hits == 0) wrap_a = k;
        else wrap_b = k;
        hits++;
      end
      k++;
    end

    key_pool[0] = col_a;
    key_pool[1] = col_b;
    key_pool[2] = wrap_a;
    key_pool[3] = wrap_b;
    for (int i = 4; i < POOL_SIZE; i++) begin
      do key_pool[i] = {$urandom, $urandom}; while (key_pool[i] <= KEY_DELETED);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corner cases
    send_request(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(CMD_REGISTER, KEY_EMPTY, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, KEY_DELETED, 16'd0, 16'd0, 32'd0);
    send_request(CMD_FORGET, KEY_EMPTY, 16'd0, 16'd0, 32'd0);
    send_request(CMD_REGISTER, KEY_DELETED, 16'h1234, 16'h5678, 32'h9ABC_DEF0);
    send_request(CMD_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, 32'd0);
    send_request(CMD_REGISTER, 64'd2, 16'd0, 16'd0, 32'd0);
    send_request(CMD_LOOKUP, 64'd2, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(CMD_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'hA5A5, 16'h5A5A, 32'h0F0F_F0F0);
    send_request(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, 32'd0);
    send_request(CMD_REGISTER, col_a, 16'd1, 16'd2, 32'd3);
    send_request(CMD_REGISTER, col_b, 16'd4, 16'd5, 32'd6);
    send_request(CMD_FORGET, col_a, 16'd0, 16'd0, 32'd0);
    send_request(CMD_LOOKUP, col_b, 16'd0, 16'd0, 32'd0);
    send_request(CMD_LOOKUP, col_a, 16'd0, 16'd0, 32'd0);
    send_request(CMD_FORGET, col_a, 16'd0, 16'd0, 32'd0);
    send_request(CMD_REGISTER, col_a, 16'd7, 16'd8, 32'd9);
    send_request(CMD_LOOKUP, col_a, 16'd0, 16'd0, 32'd0);
    send_request(CMD_REGISTER, wrap_a, 16'($urandom), 16'($urandom), $urandom);
    send_request(CMD_REGISTER, wrap_b, 16'($urandom), 16'($urandom), $urandom);
    send_request(CMD_LOOKUP, wrap_b, 16'd0, 16'd0, 32'd0);
    send_request(CMD_CLEAR, KEY_DELETED, 16'd0, 16'd0, 32'd0);
    send_request(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, 32'd0);
    send_request(CMD_FORGET, wrap_b, 16'd0, 16'd0, 32'd0);

    // random traffic under three idling profiles
    random_burst(RANDOM_ITEMS / 3);
    drain_replies();
    send_idle_pct = 82;
    recv_idle_pct = 31;
    random_burst(RANDOM_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    // empty table at the end
    drain_replies();
    send_request(CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, 32'd0);
    send_request(CMD_LOOKUP, col_a, 16'd0, 16'd0, 32'd0);

    drain_replies();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("pointer_keyed_probe_table_top regression: pass");
    end else begin
      $display("pointer_keyed_probe_table_top regression: fail");
    end
    $finish;
  end

endmodule
